// File: hdl/swim_pkg.sv
// Shared types and constants of the single-wire debug host frame engine.
package swim_pkg;

  localparam int unsigned NUM_CFG = 8;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHORT_LOW   = 4'd0,
    CFG_LONG_LOW    = 4'd1,
    CFG_BIT_PERIOD  = 4'd2,
    CFG_ACK_SAMPLE  = 4'd3,
    CFG_ZERO_THRESH = 4'd4,
    CFG_WAIT_TMO    = 4'd5,
    CFG_FIRST_NACK  = 4'd6,
    CFG_ERROR_NACK  = 4'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_SEND = 2'd1,
    FUNC_XFER = 2'd2,
    FUNC_RSVD = 2'd3
  } func_t;

  typedef enum logic [4:0] {
    PH_IDLE       = 5'd0,
    PH_TX_START   = 5'd1,
    PH_TX_DATA    = 5'd2,
    PH_TX_PAR     = 5'd3,
    PH_ACK_HI     = 5'd4,
    PH_ACK_LO     = 5'd5,
    PH_ACK_SMP    = 5'd6,
    PH_ACK_END    = 5'd7,
    PH_FIRST_LO   = 5'd8,
    PH_FNACK_DLY  = 5'd9,
    PH_ENACK_DLY  = 5'd10,
    PH_NACK_PULSE = 5'd11,
    PH_RX_HI      = 5'd12,
    PH_RX_LO      = 5'd13,
    PH_RX_SSMP    = 5'd14,
    PH_RX_BHI     = 5'd15,
    PH_RX_BLO     = 5'd16,
    PH_RX_BMEAS   = 5'd17,
    PH_RX_PHI     = 5'd18,
    PH_RX_PLO     = 5'd19,
    PH_RX_PSMP    = 5'd20,
    PH_RX_PEND    = 5'd21,
    PH_ACK_DLY    = 5'd22,
    PH_ACK_PULSE  = 5'd23,
    PH_LAST_REL   = 5'd24
  } phase_t;

  typedef struct packed {
    logic [7:0]  short_low;
    logic [7:0]  long_low;
    logic [7:0]  bit_period;
    logic [7:0]  ack_sample;
    logic [7:0]  zero_thresh;
    logic [15:0] wait_tmo;
    logic [11:0] first_nack;
    logic [11:0] error_nack;
  } cfg_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] tx_value;
    logic [3:0] tx_bits;
    logic [7:0] rx_count;
    logic       line_in;
  } item_t;

  typedef struct packed {
    logic       line_out;
    logic       busy_res;
    logic       done_res;
    logic       ok;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       rx_last;
  } res_t;

endpackage

// File: hdl/swim_cfg.sv
// Configuration register file of the frame engine.
module swim_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  logic [swim_pkg::CFG_IDX_W-1:0]      wr_idx,
  input  logic [swim_pkg::CFG_DATA_W-1:0]     wr_data,
  output swim_pkg::cfg_t                      cfg
);

  swim_pkg::cfg_t cfg_r;
  swim_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_idx)
        swim_pkg::CFG_SHORT_LOW:   cfg_nxt.short_low   = wr_data[7:0];
        swim_pkg::CFG_LONG_LOW:    cfg_nxt.long_low    = wr_data[7:0];
        swim_pkg::CFG_BIT_PERIOD:  cfg_nxt.bit_period  = wr_data[7:0];
        swim_pkg::CFG_ACK_SAMPLE:  cfg_nxt.ack_sample  = wr_data[7:0];
        swim_pkg::CFG_ZERO_THRESH: cfg_nxt.zero_thresh = wr_data[7:0];
        swim_pkg::CFG_WAIT_TMO:    cfg_nxt.wait_tmo    = wr_data[15:0];
        swim_pkg::CFG_FIRST_NACK:  cfg_nxt.first_nack  = wr_data[11:0];
        swim_pkg::CFG_ERROR_NACK:  cfg_nxt.error_nack  = wr_data[11:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_low   <= 8'd3;
      cfg_r.long_low    <= 8'd32;
      cfg_r.bit_period  <= 8'd35;
      cfg_r.ack_sample  <= 8'd3;
      cfg_r.zero_thresh <= 8'd24;
      cfg_r.wait_tmo    <= 16'd1000;
      cfg_r.first_nack  <= 12'd769;
      cfg_r.error_nack  <= 12'd97;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: hdl/swim_step.sv
// Frame sequencer: state registers and the per-tick next-state logic.
module swim_step #(
  parameter int unsigned ERROR_LIMIT     = 16,
  parameter int unsigned ACK_DELAY_TICKS = 10
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step_en,
  input  swim_pkg::item_t item,
  input  swim_pkg::cfg_t  cfg,
  output swim_pkg::res_t  res
);

  localparam logic [4:0]  ErrLimit = 5'(ERROR_LIMIT);
  localparam logic [15:0] AckDelay = 16'(ACK_DELAY_TICKS);

  swim_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] tick_count_r, tick_count_nxt;
  logic [7:0]  tx_shift_r, tx_shift_nxt;
  logic [7:0]  rx_shift_r, rx_shift_nxt;
  logic [3:0]  bits_left_r, bits_left_nxt;
  logic        parity_r, parity_nxt;
  logic [4:0]  error_count_r, error_count_nxt;
  logic [7:0]  bytes_left_r, bytes_left_nxt;
  logic        ras_r, ras_nxt;

  swim_pkg::phase_t ph_cur;
  logic [15:0] tc_cur, tc_inc, tmo;
  logic [7:0]  period, low, zth, ack_smp;
  logic [3:0]  n_bits, bits_dec;
  logic        start_go, txb, bad, fail;
  logic        drive, done, okv, rxv, rxl;
  logic [7:0]  rxb;
  logic [4:0]  err_inc;

  function automatic logic [7:0] at_least1(input logic [7:0] v);
    at_least1 = (v == 8'd0) ? 8'd1 : v;
  endfunction

  always_comb begin
    start_go = (phase_r == swim_pkg::PH_IDLE) &&
               ((item.func == swim_pkg::FUNC_SEND) || (item.func == swim_pkg::FUNC_XFER));
    if (item.func == swim_pkg::FUNC_XFER) begin
      n_bits = 4'd8;
    end else if (item.tx_bits == 4'd0) begin
      n_bits = 4'd1;
    end else if (item.tx_bits > 4'd8) begin
      n_bits = 4'd8;
    end else begin
      n_bits = item.tx_bits;
    end

    phase_nxt       = phase_r;
    tick_count_nxt  = tick_count_r;
    tx_shift_nxt    = tx_shift_r;
    rx_shift_nxt    = rx_shift_r;
    bits_left_nxt   = bits_left_r;
    parity_nxt      = parity_r;
    error_count_nxt = error_count_r;
    bytes_left_nxt  = bytes_left_r;
    ras_nxt         = ras_r;
    if (start_go) begin
      tx_shift_nxt    = item.tx_value << (4'd8 - n_bits);
      bits_left_nxt   = n_bits;
      parity_nxt      = 1'b0;
      ras_nxt         = (item.func == swim_pkg::FUNC_XFER);
      bytes_left_nxt  = (item.rx_count == 8'd0) ? 8'd1 : item.rx_count;
      error_count_nxt = 5'd0;
      rx_shift_nxt    = 8'd0;
      phase_nxt       = swim_pkg::PH_TX_START;
      tick_count_nxt  = 16'd0;
    end
    ph_cur = phase_nxt;
    tc_cur = tick_count_nxt;
    tc_inc = tc_cur + 16'd1;
    bits_dec = bits_left_nxt - 4'd1;

    period  = (cfg.bit_period < 8'd2) ? 8'd2 : cfg.bit_period;
    tmo     = (cfg.wait_tmo == 16'd0) ? 16'd1 : cfg.wait_tmo;
    zth     = at_least1(cfg.zero_thresh);
    ack_smp = at_least1(cfg.ack_sample);
    if (ph_cur == swim_pkg::PH_TX_START) begin
      txb = 1'b0;
    end else if (ph_cur == swim_pkg::PH_TX_DATA) begin
      txb = tx_shift_nxt[7];
    end else begin
      txb = parity_nxt;
    end
    low = at_least1(txb ? cfg.short_low : cfg.long_low);
    if (low > period - 8'd1) begin
      low = period - 8'd1;
    end

    drive = 1'b1;
    done  = 1'b0;
    okv   = 1'b0;
    rxv   = 1'b0;
    rxb   = 8'd0;
    rxl   = 1'b0;
    bad   = 1'b0;
    fail  = 1'b0;

    unique case (ph_cur)
      swim_pkg::PH_TX_START, swim_pkg::PH_TX_DATA: begin
        drive = !(tc_cur < {8'd0, low});
        tick_count_nxt = tc_inc;
        if (tc_inc >= {8'd0, period}) begin
          tick_count_nxt = 16'd0;
          if (ph_cur == swim_pkg::PH_TX_START) begin
            phase_nxt = swim_pkg::PH_TX_DATA;
          end else begin
            parity_nxt    = parity_nxt ^ txb;
            tx_shift_nxt  = {tx_shift_nxt[6:0], 1'b0};
            bits_left_nxt = bits_dec;
            phase_nxt = (bits_dec == 4'd0) ? swim_pkg::PH_TX_PAR : swim_pkg::PH_TX_DATA;
          end
        end
      end
      swim_pkg::PH_TX_PAR: begin
        drive = 1'b0;
        tick_count_nxt = tc_inc;
        if (tc_inc >= {8'd0, low}) begin
          phase_nxt = swim_pkg::PH_ACK_HI;
          tick_count_nxt = 16'd0;
        end
      end
      swim_pkg::PH_ACK_HI, swim_pkg::PH_RX_HI, swim_pkg::PH_RX_BHI, swim_pkg::PH_RX_PHI,
      swim_pkg::PH_ACK_LO, swim_pkg::PH_RX_LO, swim_pkg::PH_RX_PLO, swim_pkg::PH_FIRST_LO,
      swim_pkg::PH_RX_BLO, swim_pkg::PH_ACK_END, swim_pkg::PH_RX_PEND: begin
        if (item.line_in == ((ph_cur == swim_pkg::PH_ACK_HI) || (ph_cur == swim_pkg::PH_RX_HI) ||
                             (ph_cur == swim_pkg::PH_RX_BHI) || (ph_cur == swim_pkg::PH_RX_PHI) ||
                             (ph_cur == swim_pkg::PH_ACK_END) ||
                             (ph_cur == swim_pkg::PH_RX_PEND))) begin
          tick_count_nxt = 16'd0;
          case (ph_cur)
            swim_pkg::PH_ACK_HI:   phase_nxt = swim_pkg::PH_ACK_LO;
            swim_pkg::PH_RX_HI:    phase_nxt = swim_pkg::PH_RX_LO;
            swim_pkg::PH_RX_BHI:   phase_nxt = swim_pkg::PH_RX_BLO;
            swim_pkg::PH_RX_PHI:   phase_nxt = swim_pkg::PH_RX_PLO;
            swim_pkg::PH_ACK_LO:   phase_nxt = swim_pkg::PH_ACK_SMP;
            swim_pkg::PH_RX_LO:    phase_nxt = swim_pkg::PH_RX_SSMP;
            swim_pkg::PH_RX_PLO:   phase_nxt = swim_pkg::PH_RX_PSMP;
            swim_pkg::PH_FIRST_LO: phase_nxt = swim_pkg::PH_FNACK_DLY;
            swim_pkg::PH_RX_PEND:  phase_nxt = swim_pkg::PH_ACK_DLY;
            swim_pkg::PH_ACK_END: begin
              if (ras_nxt) begin
                phase_nxt = swim_pkg::PH_FIRST_LO;
              end else begin
                done = 1'b1;
                okv  = 1'b1;
                phase_nxt = swim_pkg::PH_IDLE;
              end
            end
            default: begin
              if (zth <= 8'd1) begin
                rx_shift_nxt  = {rx_shift_nxt[6:0], 1'b0};
                bits_left_nxt = bits_dec;
                phase_nxt = (bits_dec == 4'd0) ? swim_pkg::PH_RX_PHI : swim_pkg::PH_RX_BHI;
              end else begin
                tick_count_nxt = 16'd1;
                phase_nxt = swim_pkg::PH_RX_BMEAS;
              end
            end
          endcase
        end else begin
          tick_count_nxt = tc_inc;
          if (tc_inc >= tmo) begin
            fail = 1'b1;
          end
        end
      end
      swim_pkg::PH_ACK_SMP: begin
        tick_count_nxt = tc_inc;
        if (tc_inc >= {8'd0, ack_smp}) begin
          if (item.line_in) begin
            phase_nxt = swim_pkg::PH_ACK_END;
            tick_count_nxt = 16'd0;
          end else begin
            fail = 1'b1;
          end
        end
      end
      swim_pkg::PH_FNACK_DLY, swim_pkg::PH_ENACK_DLY: begin
        tick_count_nxt = tc_inc;
        if (tc_inc >= {4'd0, (ph_cur == swim_pkg::PH_FNACK_DLY) ? cfg.first_nack
                                                                 : cfg.error_nack}) begin
          phase_nxt = swim_pkg::PH_NACK_PULSE;
          tick_count_nxt = 16'd0;
        end
      end
      swim_pkg::PH_NACK_PULSE, swim_pkg::PH_ACK_PULSE: begin
        drive = 1'b0;
        tick_count_nxt = tc_inc;
        if (tc_inc >= {8'd0, at_least1((ph_cur == swim_pkg::PH_NACK_PULSE) ?
                                       cfg.long_low : cfg.short_low)}) begin
          tick_count_nxt = 16'd0;
          if ((ph_cur == swim_pkg::PH_ACK_PULSE) && (bytes_left_nxt == 8'd0)) begin
            phase_nxt = swim_pkg::PH_LAST_REL;
          end else begin
            phase_nxt = swim_pkg::PH_RX_HI;
          end
        end
      end
      swim_pkg::PH_RX_SSMP: begin
        tick_count_nxt = tc_inc;
        if (tc_inc >= {8'd0, ack_smp}) begin
          if (item.line_in) begin
            rx_shift_nxt  = 8'd0;
            bits_left_nxt = 4'd8;
            parity_nxt    = 1'b0;
            phase_nxt = swim_pkg::PH_RX_BHI;
            tick_count_nxt = 16'd0;
          end else begin
            bad = 1'b1;
          end
        end
      end
      swim_pkg::PH_RX_BMEAS: begin
        if (item.line_in || (tc_inc >= {8'd0, zth})) begin
          rx_shift_nxt  = {rx_shift_nxt[6:0], item.line_in};
          parity_nxt    = parity_nxt ^ item.line_in;
          bits_left_nxt = bits_dec;
          phase_nxt = (bits_dec == 4'd0) ? swim_pkg::PH_RX_PHI : swim_pkg::PH_RX_BHI;
          tick_count_nxt = 16'd0;
        end else begin
          tick_count_nxt = tc_inc;
        end
      end
      swim_pkg::PH_RX_PSMP: begin
        tick_count_nxt = tc_inc;
        if (tc_inc >= {8'd0, ack_smp}) begin
          if (item.line_in == parity_nxt) begin
            rxv = 1'b1;
            rxb = rx_shift_nxt;
            rxl = (bytes_left_nxt == 8'd1);
            bytes_left_nxt  = bytes_left_nxt - 8'd1;
            error_count_nxt = 5'd0;
            phase_nxt = swim_pkg::PH_RX_PEND;
            tick_count_nxt = 16'd0;
          end else begin
            bad = 1'b1;
          end
        end
      end
      swim_pkg::PH_ACK_DLY: begin
        tick_count_nxt = tc_inc;
        if (tc_inc >= AckDelay) begin
          phase_nxt = swim_pkg::PH_ACK_PULSE;
          tick_count_nxt = 16'd0;
        end
      end
      swim_pkg::PH_LAST_REL: begin
        done = 1'b1;
        okv  = 1'b1;
        phase_nxt = swim_pkg::PH_IDLE;
        tick_count_nxt = 16'd0;
      end
      default: begin
        phase_nxt = swim_pkg::PH_IDLE;
        tick_count_nxt = 16'd0;
      end
    endcase

    err_inc = error_count_nxt + 5'd1;
    if (bad) begin
      error_count_nxt = err_inc;
      if (err_inc >= ErrLimit) begin
        fail = 1'b1;
      end else begin
        phase_nxt = swim_pkg::PH_ENACK_DLY;
        tick_count_nxt = 16'd0;
      end
    end
    if (fail) begin
      done = 1'b1;
      okv  = 1'b0;
      phase_nxt = swim_pkg::PH_IDLE;
      tick_count_nxt = 16'd0;
    end

    res.line_out = drive;
    res.busy_res = (phase_nxt != swim_pkg::PH_IDLE);
    res.done_res = done;
    res.ok       = okv;
    res.rx_valid = rxv;
    res.rx_byte  = rxb;
    res.rx_last  = rxl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= swim_pkg::PH_IDLE;
      tick_count_r  <= 16'd0;
      tx_shift_r    <= 8'd0;
      rx_shift_r    <= 8'd0;
      bits_left_r   <= 4'd0;
      parity_r      <= 1'b0;
      error_count_r <= 5'd0;
      bytes_left_r  <= 8'd0;
      ras_r         <= 1'b0;
    end else if (step_en) begin
      phase_r       <= phase_nxt;
      tick_count_r  <= tick_count_nxt;
      tx_shift_r    <= tx_shift_nxt;
      rx_shift_r    <= rx_shift_nxt;
      bits_left_r   <= bits_left_nxt;
      parity_r      <= parity_nxt;
      error_count_r <= error_count_nxt;
      bytes_left_r  <= bytes_left_nxt;
      ras_r         <= ras_nxt;
    end
  end

endmodule

// File: hdl/swim_host_frame_engine.sv
// Single-wire debug host frame engine: each request is one sampling tick of the wire and
// returns exactly one result with the host drive level and status for that tick. One
// request is taken every clock cycle while the output side accepts results; a request is
// held in the input register and its result is captured in the output register when the
// single-pass sequencer step advances, which stalls while a held result is not accepted.
// Configuration writes are taken at any time and must only be issued while idle.
module swim_host_frame_engine #(
  parameter int unsigned ERROR_LIMIT     = 16,
  parameter int unsigned ACK_DELAY_TICKS = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_func,
  input  logic [7:0]                      in_tx_value,
  input  logic [3:0]                      in_tx_bits,
  input  logic [7:0]                      in_rx_count,
  input  logic                            in_line_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_line_out,
  output logic                            out_busy_res,
  output logic                            out_done_res,
  output logic                            out_ok,
  output logic                            out_rx_valid,
  output logic [7:0]                      out_rx_byte,
  output logic                            out_rx_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [swim_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swim_pkg::CFG_DATA_W-1:0] cfg_data
);

  swim_pkg::cfg_t  cfg;
  swim_pkg::item_t item_r;
  swim_pkg::res_t  res, res_r;
  logic            in_vld_r;
  logic            out_vld_r;
  logic            advance;

  assign advance   = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || advance;
  assign cfg_ready = 1'b1;

  swim_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  swim_step #(
    .ERROR_LIMIT     (ERROR_LIMIT),
    .ACK_DELAY_TICKS (ACK_DELAY_TICKS)
  ) u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (item_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.func     <= in_func;
      item_r.tx_value <= in_tx_value;
      item_r.tx_bits  <= in_tx_bits;
      item_r.rx_count <= in_rx_count;
      item_r.line_in  <= in_line_in;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid    = out_vld_r;
  assign out_line_out = res_r.line_out;
  assign out_busy_res = res_r.busy_res;
  assign out_done_res = res_r.done_res;
  assign out_ok       = res_r.ok;
  assign out_rx_valid = res_r.rx_valid;
  assign out_rx_byte  = res_r.rx_byte;
  assign out_rx_last  = res_r.rx_last;

endmodule
